// File: hdl/utfpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpe_pkg: shared types and helpers for the UTF-16 percent escaper
// Job record, unit encoding record and the hex digit map.
// ----------------------------------------------------------------------------
package utfpe_pkg;

  localparam int unsigned UnitW    = 16;
  localparam int unsigned CountW   = 16;
  localparam logic [UnitW-1:0] CapReset = 16'd260;
  localparam logic [UnitW-1:0] CharPercent = 16'h0025;

  // What a pending job emits
  typedef enum logic [1:0] {
    KIND_COPY = 2'd0,   // one copied unit
    KIND_TERM = 2'd1,   // terminating zero
    KIND_ESC  = 2'd2    // percent escape, one to three bytes
  } kind_e;

  // Classification and UTF-8 bytes of one code unit
  typedef struct packed {
    logic            copy;     // passes through unchanged
    logic [2:0][7:0] bytes;    // escape bytes, index 0 first
    logic [1:0]      nb_m1;    // byte count minus one
    logic [3:0]      need;     // characters the escape takes
  } enc_t;

  // One accepted unit waiting to be emitted
  typedef struct packed {
    kind_e            kind;
    logic [UnitW-1:0] unit;
    logic [2:0][7:0]  bytes;
    logic [1:0]       nb_m1;
  } job_t;

  // Upper-case hex digit as a 16-bit character
  function automatic logic [UnitW-1:0] hex_char(input logic [3:0] nib);
    logic [UnitW-1:0] c;
    if (nib < 4'd10) begin
      c = 16'h0030 + {12'd0, nib};
    end else begin
      c = 16'h0041 + {12'd0, nib} - 16'd10;
    end
    return c;
  endfunction

endpackage

// File: hdl/utfpe_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpe_encode: code unit classifier and UTF-8 encoder
// Decides pass-through versus escape and forms the escape bytes.
// ----------------------------------------------------------------------------
module utfpe_encode import utfpe_pkg::*; (
  input  logic [UnitW-1:0] unit_i,
  output enc_t             enc_o
);

  logic is_digit, is_upper, is_lower, is_slash;
  logic is_surr, is_one, is_two;

  assign is_digit = (unit_i >= 16'h0030) && (unit_i <= 16'h0039);
  assign is_upper = (unit_i >= 16'h0041) && (unit_i <= 16'h005A);
  assign is_lower = (unit_i >= 16'h0061) && (unit_i <= 16'h007A);
  assign is_slash = (unit_i == 16'h002F) || (unit_i == 16'h005C);

  assign is_surr = (unit_i[15:11] == 5'b11011);
  assign is_one  = (unit_i[15:7] == 9'd0);
  assign is_two  = (unit_i[15:11] == 5'd0);

  always_comb begin
    enc_o.copy  = is_digit | is_upper | is_lower | is_slash;
    enc_o.bytes = '0;
    if (is_surr) begin
      enc_o.bytes[0] = 8'hFF;
      enc_o.nb_m1    = 2'd0;
      enc_o.need     = 4'd3;
    end else if (is_one) begin
      enc_o.bytes[0] = unit_i[7:0];
      enc_o.nb_m1    = 2'd0;
      enc_o.need     = 4'd3;
    end else if (is_two) begin
      enc_o.bytes[0] = {3'b110, unit_i[10:6]};
      enc_o.bytes[1] = {2'b10, unit_i[5:0]};
      enc_o.nb_m1    = 2'd1;
      enc_o.need     = 4'd6;
    end else begin
      enc_o.bytes[0] = {4'b1110, unit_i[15:12]};
      enc_o.bytes[1] = {2'b10, unit_i[11:6]};
      enc_o.bytes[2] = {2'b10, unit_i[5:0]};
      enc_o.nb_m1    = 2'd2;
      enc_o.need     = 4'd9;
    end
  end

endmodule

// File: hdl/utf16_percent_escaper_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_percent_escaper_core: percent escaper for a UTF-16 unit stream
// Copies digits, letters and slashes; escapes all else as %XX per UTF-8 byte.
// ----------------------------------------------------------------------------
// Usage: each accepted code unit is classified and checked against the room
// left in the output buffer in the cycle it is accepted, then parked in a
// one-entry job register. Unless stalled, the emitter drains that job one
// character per cycle into the output register: a copied unit or terminator
// is one character, an escaped unit three per UTF-8 byte (up to nine). The
// next unit is taken in the cycle the job hands over its last character, so
// without stalls copied units stream at one transaction per cycle and output
// throughput is one character per cycle, set by the single output register.
// A zero unit always yields a terminator and restarts the count; units that
// do not fit, and all later units up to the terminator, yield nothing. The
// capacity register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module utf16_percent_escaper_core import utfpe_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration: output_capacity
  input  logic             cfg_we_i,
  input  logic [UnitW-1:0] cfg_wdata_i,
  // input channel
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [UnitW-1:0] code_unit_i,
  // output channel
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [UnitW-1:0] out_char_o,
  output logic             last_of_run_o,
  output logic             end_of_string_o
);

  logic [UnitW-1:0]  cap_q;
  logic [CountW-1:0] chars_q, chars_d;
  logic              stopped_q, stopped_d;

  logic              job_valid_q, job_valid_d;
  job_t              job_q, job_d;
  logic [1:0]        sel_q, sel_d;   // current byte of an escape
  logic [1:0]        pos_q, pos_d;   // 0: '%', 1: high nibble, 2: low nibble

  logic              out_valid_q, out_valid_d;
  logic [UnitW-1:0]  out_char_q, out_char_d;
  logic              out_last_q, out_last_d;
  logic              out_eos_q, out_eos_d;

  enc_t              enc;
  logic              in_acc, emit, emit_last, job_load;
  logic [UnitW-1:0]  limit;
  logic [CountW+1:0] sum_copy, sum_esc;
  logic [UnitW-1:0]  emit_char;
  logic [7:0]        cur_byte;

  utfpe_encode u_encode (
    .unit_i (code_unit_i),
    .enc_o  (enc)
  );

  // capacity includes the terminator; zero capacity leaves no room for other chars
  assign limit    = (cap_q == '0) ? '0 : cap_q - 16'd1;
  assign sum_copy = {2'b00, chars_q} + 18'd1;
  assign sum_esc  = {2'b00, chars_q} + {14'd0, enc.need};

  // emitter: one character per cycle into the output register while not stalled
  assign emit = job_valid_q && (!out_valid_q || !out_stall_i);

  always_comb begin
    case (sel_q)
      2'd0:    cur_byte = job_q.bytes[0];
      2'd1:    cur_byte = job_q.bytes[1];
      2'd2:    cur_byte = job_q.bytes[2];
      default: cur_byte = job_q.bytes[0];
    endcase
  end

  always_comb begin
    emit_char = job_q.unit;
    emit_last = 1'b1;
    if (job_q.kind == KIND_ESC) begin
      emit_last = (pos_q == 2'd2) && (sel_q == job_q.nb_m1);
      case (pos_q)
        2'd0:    emit_char = CharPercent;
        2'd1:    emit_char = hex_char(cur_byte[7:4]);
        2'd2:    emit_char = hex_char(cur_byte[3:0]);
        default: emit_char = CharPercent;
      endcase
    end
  end

  // a new transaction enters once the job slot is free or freeing
  assign in_stall_o = job_valid_q && !(emit && emit_last);
  assign in_acc     = in_valid_i && !in_stall_o;

  // decision and count update at acceptance
  always_comb begin
    chars_d   = chars_q;
    stopped_d = stopped_q;
    job_load  = 1'b0;
    job_d     = job_q;
    if (in_acc) begin
      job_d.unit  = code_unit_i;
      job_d.bytes = enc.bytes;
      job_d.nb_m1 = enc.nb_m1;
      if (code_unit_i == '0) begin
        job_d.kind = KIND_TERM;
        job_load   = 1'b1;
        chars_d    = '0;
        stopped_d  = 1'b0;
      end else if (!stopped_q) begin
        if (enc.copy) begin
          job_d.kind = KIND_COPY;
          if (sum_copy > {2'b00, limit}) begin
            stopped_d = 1'b1;
          end else begin
            job_load = 1'b1;
            chars_d  = sum_copy[CountW-1:0];
          end
        end else begin
          job_d.kind = KIND_ESC;
          if (sum_esc > {2'b00, limit}) begin
            stopped_d = 1'b1;
          end else begin
            job_load = 1'b1;
            chars_d  = sum_esc[CountW-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    sel_d       = sel_q;
    pos_d       = pos_q;
    if (emit) begin
      if (emit_last) begin
        job_valid_d = 1'b0;
      end else if (pos_q == 2'd2) begin
        pos_d = 2'd0;
        sel_d = sel_q + 2'd1;
      end else begin
        pos_d = pos_q + 2'd1;
      end
    end
    if (job_load) begin
      job_valid_d = 1'b1;
      sel_d       = 2'd0;
      pos_d       = 2'd0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    out_eos_d   = out_eos_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_last_d  = emit_last;
      out_eos_d   = (job_q.kind == KIND_TERM);
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      chars_q     <= '0;
      stopped_q   <= 1'b0;
      job_valid_q <= 1'b0;
      sel_q       <= '0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      chars_q     <= chars_d;
      stopped_q   <= stopped_d;
      job_valid_q <= job_valid_d;
      sel_q       <= sel_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    out_eos_q  <= out_eos_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_char_o      = out_char_q;
  assign last_of_run_o   = out_last_q;
  assign end_of_string_o = out_eos_q;

endmodule

// File: verif/utfpe_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utfpe_tb_pkg: scoreboard for the UTF-16 percent escaper testbench
// Predicts the escaped character stream and checks the block's output.
// ----------------------------------------------------------------------------
package utfpe_tb_pkg;

  // One emitted character as the block presents it
  typedef struct packed {
    logic [15:0] ch;
    logic        last;
    logic        eos;
  } esc_char_t;

  // Digits, ASCII letters, slash and backslash are copied as they are
  function automatic bit is_plain_unit(logic [15:0] u);
    return (u >= 16'h0030 && u <= 16'h0039) || (u >= 16'h0041 && u <= 16'h005A) ||
           (u >= 16'h0061 && u <= 16'h007A) || u == 16'h002F || u == 16'h005C;
  endfunction

  class escape_scoreboard;
    int unsigned capacity;
    int unsigned chars_in_string;
    bit          stopped;
    esc_char_t   pending_chars[$];
    int          failures;
    int          checked;
    int          strings;

    function new();
      capacity        = 260;
      chars_in_string = 0;
      stopped         = 0;
      failures        = 0;
      checked         = 0;
      strings         = 0;
    endfunction

    function void set_capacity(logic [15:0] v);
      capacity = v;
    endfunction

    function int pending();
      return pending_chars.size();
    endfunction

    function void add_char(logic [15:0] ch, logic last, logic eos);
      esc_char_t c;
      c.ch   = ch;
      c.last = last;
      c.eos  = eos;
      pending_chars.push_back(c);
    endfunction

    // Accepted input unit: work out the characters it must produce
    function void note_unit(logic [15:0] u);
      string       hexset;
      int unsigned room;
      logic [7:0]  utf8 [3];
      int unsigned nb;
      hexset = "0123456789ABCDEF";
      room   = (capacity == 0) ? 0 : capacity - 1;
      if (u == 16'h0000) begin
        add_char(16'h0000, 1'b1, 1'b1);
        chars_in_string = 0;
        stopped         = 0;
        return;
      end
      if (stopped) return;
      if (is_plain_unit(u)) begin
        if (chars_in_string + 1 > room) begin
          stopped = 1;
        end else begin
          add_char(u, 1'b1, 1'b0);
          chars_in_string++;
        end
        return;
      end
      // UTF-8 bytes; a lone surrogate becomes 0xFF
      if (u >= 16'hD800 && u <= 16'hDFFF) begin
        utf8[0] = 8'hFF;
        nb      = 1;
      end else if (u < 16'h0080) begin
        utf8[0] = u[7:0];
        nb      = 1;
      end else if (u < 16'h0800) begin
        utf8[0] = 8'hC0 | {3'b000, u[10:6]};
        utf8[1] = 8'h80 | {2'b00, u[5:0]};
        nb      = 2;
      end else begin
        utf8[0] = 8'hE0 | {4'h0, u[15:12]};
        utf8[1] = 8'h80 | {2'b00, u[11:6]};
        utf8[2] = 8'h80 | {2'b00, u[5:0]};
        nb      = 3;
      end
      if (chars_in_string + 3 * nb > room) begin
        stopped = 1;
        return;
      end
      for (int unsigned i = 0; i < nb; i++) begin
        add_char(16'h0025, 1'b0, 1'b0);
        add_char({8'h00, hexset[utf8[i][7:4]]}, 1'b0, 1'b0);
        add_char({8'h00, hexset[utf8[i][3:0]]}, i == nb - 1, 1'b0);
      end
      chars_in_string = (chars_in_string + 3 * nb) & 32'h0000_FFFF;
    endfunction

    // Accepted output transaction: compare with the oldest prediction
    function void check_char(logic [15:0] ch, logic last, logic eos);
      esc_char_t want;
      checked++;
      if (pending_chars.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected char %h last %b eos %b: nothing pending", ch, last, eos);
        return;
      end
      want = pending_chars.pop_front();
      if (want.eos) strings++;
      if (want.ch !== ch || want.last !== last || want.eos !== eos) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: got char %h last %b eos %b, expected char %h last %b eos %b",
                   ch, last, eos, want.ch, want.last, want.eos);
      end
    endfunction

    function void flush_check();
      if (pending_chars.size() != 0) begin
        failures++;
        $display("%0d predicted chars never came out", pending_chars.size());
      end
    endfunction
  endclass

endpackage

// File: verif/utf16_percent_escaper_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf16_percent_escaper_core_tb: self-checking bench for the percent escaper
// Streams UTF-16 strings through the core under several buffer capacities
// with random gaps and output stalls, and checks every emitted character.
// ----------------------------------------------------------------------------
module utf16_percent_escaper_core_tb import utfpe_pkg::*, utfpe_tb_pkg::*;;

  localparam int CycleLimit  = 400000; // far above the slowest legal run
  localparam int SettleCycles = 20;    // a nine-char escape plus margin
  localparam int RandPhases  = 8;
  localparam int PhaseUnits  = 55;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [UnitW-1:0] cfg_wdata_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [UnitW-1:0] code_unit_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [UnitW-1:0] out_char_o;
  logic             last_of_run_o;
  logic             end_of_string_o;

  escape_scoreboard sb;
  bit               gaps_on;    // sender inserts idle bursts
  bit               stalls_on;  // receiver inserts stall bursts
  int               units_sent;
  int               stall_left;

  utf16_percent_escaper_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .code_unit_i     (code_unit_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o),
    .end_of_string_o (end_of_string_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop if the run hangs
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("timeout after %0d cycles, %0d chars still pending", CycleLimit, sb.pending());
    $display("utf16_percent_escaper_core_tb NOT OK");
    $finish;
  end

  // Receiver: stall in bursts of random length while stalls_on is set.
  // One nonblocking write of out_stall_i per edge.
  always @(posedge clk_i) begin
    if (!stalls_on) begin
      stall_left  <= 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Monitor: values are sampled at the edge, before any driver update lands.
  // The output check goes first; a unit accepted now cannot show up yet.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        sb.check_char(out_char_o, last_of_run_o, end_of_string_o);
      if (in_valid_i && !in_stall_o) begin
        sb.note_unit(code_unit_i);
        units_sent++;
      end
    end
  end

  // Present one unit and hold it until the block takes the transaction
  task automatic send_unit(input logic [UnitW-1:0] u);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    code_unit_i <= u;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_units(input logic [UnitW-1:0] seq[$]);
    foreach (seq[i]) send_unit(seq[i]);
  endtask

  // Capacity may only change while the block is idle: let the monitor note
  // the last transaction, drain all pending chars, then wait SettleCycles
  // more as a margin before writing.
  task automatic write_capacity(input logic [UnitW-1:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    sb.set_capacity(v);
    cfg_we_i <= 1'b0;
  endtask

  // Mix of unit classes: copied chars, one-, two- and three-byte escapes,
  // lone surrogates and a few fully random units.
  function automatic logic [UnitW-1:0] pick_code_unit();
    logic [UnitW-1:0] u;
    int               r;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      case ($urandom_range(0, 4))
        0:       u = 16'h0030 + 16'($urandom_range(0, 9));
        1:       u = 16'h0041 + 16'($urandom_range(0, 25));
        2:       u = 16'h0061 + 16'($urandom_range(0, 25));
        3:       u = 16'h002F;
        default: u = 16'h005C;
      endcase
    end else if (r < 50) begin
      do u = 16'($urandom_range(1, 16'h007F)); while (is_plain_unit(u));
    end else if (r < 65) begin
      u = 16'($urandom_range(16'h0080, 16'h07FF));
    end else if (r < 88) begin
      do u = 16'($urandom_range(16'h0800, 16'hFFFF)); while (u >= 16'hD800 && u <= 16'hDFFF);
    end else if (r < 95) begin
      u = 16'($urandom_range(16'hD800, 16'hDFFF));
    end else begin
      u = 16'($urandom_range(1, 16'hFFFF));
    end
    return u;
  endfunction

  // Zero-terminated strings of random length; the last one of a phase may
  // stay open so its count carries over the next capacity change.
  task automatic send_random_strings(input int n);
    int sent;
    int len;
    sent = 0;
    while (sent < n) begin
      len = $urandom_range(0, 24);
      for (int i = 0; i < len && sent < n; i++) begin
        send_unit(pick_code_unit());
        sent++;
      end
      if (sent < n) begin
        send_unit(16'h0000);
        sent++;
      end
    end
  endtask

  initial begin
    logic [UnitW-1:0] seq[$];
    logic [UnitW-1:0] cap;
    int               waited;
    sb          = new();
    units_sent  = 0;
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    code_unit_i = '0;
    out_stall_i = 1'b0;
    stall_left  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: empty string, copy-class edges, escape-class edges
    // (control char, top of ASCII, two- and three-byte ranges, surrogates).
    seq = '{16'h0000, "0", "9", "A", "Z", "a", "z", "/", "\\", 16'h0001, 16'h0025,
            16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD800, 16'hDFFF, 16'hFFFF,
            16'h0000};
    send_units(seq);

    // Capacity five: four chars of room. Copy that does not fit stops
    // output, later units are dropped, the terminator still comes out and
    // clears the stop; an escape is taken only with room for all of it.
    write_capacity(16'd5);
    seq = '{"A", "B", "C", "D", "E", 16'h0025, 16'h0000, 16'h0021, "x", 16'h0000,
            16'h0800, "a", 16'h0000};
    send_units(seq);

    // Zero capacity: nothing fits, only the terminator appears
    write_capacity(16'd0);
    seq = '{"a", 16'h0000};
    send_units(seq);

    // Random strings over a spread of capacities; last phase runs flat out
    for (int p = 0; p < RandPhases; p++) begin
      case (p)
        0:       cap = 16'd5;
        1:       cap = 16'd65535;
        2:       cap = 16'($urandom_range(6, 40));
        3:       cap = CapReset;
        4:       cap = 16'($urandom_range(5, 300));
        5:       cap = 16'($urandom_range(6, 24));
        6:       cap = 16'($urandom_range(10, 60));
        default: cap = 16'd17;
      endcase
      write_capacity(cap);
      if (p == RandPhases - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      send_random_strings(PhaseUnits);
    end
    in_valid_i <= 1'b0;

    // Drain, then leave time for anything stray to show up
    waited = 0;
    while (sb.pending() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    sb.flush_check();

    $display("sent %0d code units in strings under capacities from 0 to 65535,", units_sent);
    $display("checked %0d output chars including %0d terminators, %0d failures",
             sb.checked, sb.strings, sb.failures);
    if (sb.failures == 0) begin
      $display("utf16_percent_escaper_core_tb OK");
    end else begin
      $display("utf16_percent_escaper_core_tb NOT OK");
    end
    $finish;
  end

endmodule
